@@ design/obot_pkg.sv @@
// ----------------------------------------------------------------------------
// obot_pkg: shared types and constants for the oriented box overlap test
// Fixed point formats, the quarter-wave sine table and the stage structs.
// ----------------------------------------------------------------------------
package obot_pkg;

  localparam int CoordFracBits = 4;
  localparam int TrigFracBits  = 14;
  // center offsets carry 2^CoordFracBits, extents carry 2^TrigFracBits
  localparam int SepShift      = TrigFracBits - CoordFracBits;

  localparam int DegHalfTurn   = 180;
  localparam int DegQuarter    = 90;
  localparam int DegFullTurn   = 360;

  localparam int TabW  = TrigFracBits + 1;   // 0 .. 2^TrigFracBits
  localparam int TrigW = TrigFracBits + 2;   // signed sin/cos
  localparam int DimW  = 10;
  localparam int HalfW = DimW - 1;
  localparam int CoordW = 16;
  localparam int DiffW = CoordW + 1;
  localparam int AngW  = 9;
  localparam int IdxW  = 7;

  localparam int PdW   = TrigW + DiffW + 1;  // ax*dx + ay*dy
  localparam int UW    = 2 * TrigW;          // ax*c + ay*s (signed)
  localparam int UAbsW = UW - 1;
  localparam int RW    = HalfW + UAbsW;
  localparam int CmpW  = RW + 4;

  localparam int InTdataW  = 128;
  localparam int OutTdataW = 8;

  // Taylor series in Q2.30, rounded to the table precision
  function automatic logic [DegQuarter:0][TabW-1:0] sin_table();
    logic [DegQuarter:0][TabW-1:0] t;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] sum;
    logic [63:0] term;
    for (int d = 0; d <= DegQuarter; d++) begin
      x    = ((64'(d) * 64'd13493037705) / 64'd180 + 64'd2) >> 2;
      x2   = (x * x) >> 30;
      sum  = x;
      term = x;
      term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
      sum  = (sum + (64'd1 << (29 - TrigFracBits))) >> (30 - TrigFracBits);
      t[d] = sum[TabW-1:0];
    end
    return t;
  endfunction

  localparam logic [DegQuarter:0][TabW-1:0] SinTab = sin_table();

  typedef struct packed {
    logic signed [TrigW-1:0] sa;
    logic signed [TrigW-1:0] ca;
    logic signed [TrigW-1:0] sb;
    logic signed [TrigW-1:0] cb;
    logic [HalfW-1:0]        hxa;
    logic [HalfW-1:0]        hya;
    logic [HalfW-1:0]        hxb;
    logic [HalfW-1:0]        hyb;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
  } box_pair_t;

  typedef struct packed {
    logic signed [TrigW-1:0] ax;
    logic signed [TrigW-1:0] ay;
    logic                    live;
  } axis_t;

endpackage

@@ design/obot_trig.sv @@
// ----------------------------------------------------------------------------
// obot_trig: sine and cosine of a whole-degree angle
// Folds the angle into one turn and one quadrant, reads the quarter table.
// ----------------------------------------------------------------------------
module obot_trig (
  input  logic [obot_pkg::AngW-1:0]         angle_i,
  output logic signed [obot_pkg::TrigW-1:0] sin_o,
  output logic signed [obot_pkg::TrigW-1:0] cos_o
);

  localparam logic [obot_pkg::AngW-1:0] Full =
    obot_pkg::AngW'(obot_pkg::DegFullTurn);
  localparam logic [obot_pkg::AngW-1:0] Half =
    obot_pkg::AngW'(obot_pkg::DegHalfTurn);
  localparam logic [obot_pkg::AngW-1:0] Quarter =
    obot_pkg::AngW'(obot_pkg::DegQuarter);
  localparam logic [obot_pkg::AngW-1:0] ThreeQ =
    obot_pkg::AngW'(obot_pkg::DegHalfTurn + obot_pkg::DegQuarter);

  function automatic logic signed [obot_pkg::TrigW-1:0] sin_fold(
    input logic [obot_pkg::AngW-1:0] d
  );
    logic [obot_pkg::AngW-1:0] idx;
    logic                      neg;
    logic [obot_pkg::TabW-1:0] mag;
    if (d <= Quarter) begin
      idx = d;          neg = 1'b0;
    end else if (d <= Half) begin
      idx = Half - d;   neg = 1'b0;
    end else if (d <= ThreeQ) begin
      idx = d - Half;   neg = 1'b1;
    end else begin
      idx = Full - d;   neg = 1'b1;
    end
    mag = obot_pkg::SinTab[idx[obot_pkg::IdxW-1:0]];
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  logic [obot_pkg::AngW-1:0] ang_w;
  logic [obot_pkg::AngW:0]   cos_sum;
  logic [obot_pkg::AngW-1:0] cos_ang;

  assign ang_w   = (angle_i >= Full) ? angle_i - Full : angle_i;
  assign cos_sum = {1'b0, ang_w} + {1'b0, Quarter};
  assign cos_ang = (cos_sum >= {1'b0, Full}) ? obot_pkg::AngW'(cos_sum - {1'b0, Full})
                                             : cos_sum[obot_pkg::AngW-1:0];

  assign sin_o = sin_fold(ang_w);
  assign cos_o = sin_fold(cos_ang);

endmodule

@@ design/obot_axis.sv @@
// ----------------------------------------------------------------------------
// obot_axis: gap test of both boxes on one axis
// Three register stages: dot products, extent products, wide compare.
// Each box projects to center +- (hx*|u| + hy*|v|) on the axis.
// ----------------------------------------------------------------------------
module obot_axis (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  obot_pkg::box_pair_t   pair_i,
  input  obot_pkg::axis_t       axis_i,
  output logic                  sep_o
);

  // stage 2: dot products
  logic signed [obot_pkg::PdW-1:0] pd_d, pd_q;
  logic signed [obot_pkg::UW-1:0]  ua_s, va_s, ub_s, vb_s;
  logic [obot_pkg::UAbsW-1:0]      ua_q, va_q, ub_q, vb_q;
  logic [obot_pkg::HalfW-1:0]      hxa_q, hya_q, hxb_q, hyb_q;
  logic                            live2_q;

  // stage 3: extent products
  logic [obot_pkg::PdW-2:0]        pdabs_q;
  logic [obot_pkg::RW-1:0]         r0_q, r1_q, r2_q, r3_q;
  logic                            live3_q;

  // stage 4: compare operands
  logic [obot_pkg::CmpW-1:0]       lhs_d, lhs_q, rhs_d, rhs_q;
  logic                            live4_q;

  function automatic logic [obot_pkg::UAbsW-1:0] mag_u(
    input logic signed [obot_pkg::UW-1:0] v
  );
    logic signed [obot_pkg::UW-1:0] a;
    a = (v < 0) ? -v : v;
    return a[obot_pkg::UAbsW-1:0];
  endfunction

  assign pd_d = obot_pkg::PdW'(axis_i.ax * pair_i.dx) + obot_pkg::PdW'(axis_i.ay * pair_i.dy);
  assign ua_s = obot_pkg::UW'(axis_i.ax * pair_i.ca) + obot_pkg::UW'(axis_i.ay * pair_i.sa);
  assign va_s = obot_pkg::UW'(axis_i.ay * pair_i.ca) - obot_pkg::UW'(axis_i.ax * pair_i.sa);
  assign ub_s = obot_pkg::UW'(axis_i.ax * pair_i.cb) + obot_pkg::UW'(axis_i.ay * pair_i.sb);
  assign vb_s = obot_pkg::UW'(axis_i.ay * pair_i.cb) - obot_pkg::UW'(axis_i.ax * pair_i.sb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      live2_q <= 1'b0;
      live3_q <= 1'b0;
      live4_q <= 1'b0;
    end else if (en_i) begin
      live2_q <= axis_i.live;
      live3_q <= live2_q;
      live4_q <= live3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pd_q  <= pd_d;
      ua_q  <= mag_u(ua_s);
      va_q  <= mag_u(va_s);
      ub_q  <= mag_u(ub_s);
      vb_q  <= mag_u(vb_s);
      hxa_q <= pair_i.hxa;
      hya_q <= pair_i.hya;
      hxb_q <= pair_i.hxb;
      hyb_q <= pair_i.hyb;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pdabs_q <= (pd_q < 0) ? (obot_pkg::PdW-1)'(-pd_q) : pd_q[obot_pkg::PdW-2:0];
      r0_q    <= obot_pkg::RW'(hxa_q) * obot_pkg::RW'(ua_q);
      r1_q    <= obot_pkg::RW'(hya_q) * obot_pkg::RW'(va_q);
      r2_q    <= obot_pkg::RW'(hxb_q) * obot_pkg::RW'(ub_q);
      r3_q    <= obot_pkg::RW'(hyb_q) * obot_pkg::RW'(vb_q);
    end
  end

  assign lhs_d = obot_pkg::CmpW'(pdabs_q) << obot_pkg::SepShift;
  assign rhs_d = obot_pkg::CmpW'(r0_q) + obot_pkg::CmpW'(r1_q)
               + obot_pkg::CmpW'(r2_q) + obot_pkg::CmpW'(r3_q);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lhs_q   <= lhs_d;
      rhs_q   <= rhs_d;
    end
  end

  // touching intervals do not separate
  assign sep_o = live4_q && (lhs_q > rhs_q);

endmodule

@@ design/oriented_box_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// oriented_box_overlap_test_core: separating axis test of two rotated boxes
// Streams box pairs in, one overlap flag out per pair.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one box pair per beat (width, height, Q11.4 center and
//   angle in degrees of each box); m_axis returns one beat per pair with
//   the overlap flag in tdata bit 0 (1 = no separating axis found).
//   From the input beat to the output beat a pair passes the registers of
//   trig lookup, dot products, extent products, wide compare and result.
//   Throughput is one pair per cycle unless the output stalls; the four axes
//   each have their own multiplier set, so nothing is shared between beats.
//   The whole pipeline advances together; while the output beat waits on
//   m_axis_tready every stage holds and s_axis_tready is low, so no
//   beat is lost or repeated. Bubbles drain whenever the output is free.
//   Reset clears all valid bits; the block keeps no other state.
// ----------------------------------------------------------------------------
module oriented_box_overlap_test_core (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // a_width[9:0] a_height[19:10] a_center_x[35:20] a_center_y[51:36]
  // a_angle[60:52] b_width[70:61] b_height[80:71] b_center_x[96:81]
  // b_center_y[112:97] b_angle[121:113], zero above
  input  logic [obot_pkg::InTdataW-1:0]      s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // overlap[0], zero above
  output logic [obot_pkg::OutTdataW-1:0]     m_axis_tdata
);

  logic en;
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic overlap_q;

  logic [9:0]  a_width, a_height, b_width, b_height;
  logic signed [15:0] a_cx, a_cy, b_cx, b_cy;
  logic [8:0]  a_angle, b_angle;

  logic signed [obot_pkg::TrigW-1:0] sa, ca, sb, cb;
  obot_pkg::box_pair_t pair_d, pair_q;
  obot_pkg::axis_t     axis [4];
  logic [3:0]          sep;

  assign a_width  = s_axis_tdata[9:0];
  assign a_height = s_axis_tdata[19:10];
  assign a_cx     = s_axis_tdata[35:20];
  assign a_cy     = s_axis_tdata[51:36];
  assign a_angle  = s_axis_tdata[60:52];
  assign b_width  = s_axis_tdata[70:61];
  assign b_height = s_axis_tdata[80:71];
  assign b_cx     = s_axis_tdata[96:81];
  assign b_cy     = s_axis_tdata[112:97];
  assign b_angle  = s_axis_tdata[121:113];

  assign en            = !out_v_q || m_axis_tready;
  assign s_axis_tready = en;

  obot_trig u_trig_a (.angle_i(a_angle), .sin_o(sa), .cos_o(ca));
  obot_trig u_trig_b (.angle_i(b_angle), .sin_o(sb), .cos_o(cb));

  always_comb begin
    pair_d.sa  = sa;
    pair_d.ca  = ca;
    pair_d.sb  = sb;
    pair_d.cb  = cb;
    pair_d.hxa = a_width[9:1];
    pair_d.hya = a_height[9:1];
    pair_d.hxb = b_width[9:1];
    pair_d.hyb = b_height[9:1];
    pair_d.dx  = obot_pkg::DiffW'(a_cx) - obot_pkg::DiffW'(b_cx);
    pair_d.dy  = obot_pkg::DiffW'(a_cy) - obot_pkg::DiffW'(b_cy);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pair_q <= pair_d;
    end
  end

  // top and side edge normals of each box
  always_comb begin
    axis[0].ax = -pair_q.sa; axis[0].ay = pair_q.ca; axis[0].live = pair_q.hxa != '0;
    axis[1].ax = pair_q.ca;  axis[1].ay = pair_q.sa; axis[1].live = pair_q.hya != '0;
    axis[2].ax = -pair_q.sb; axis[2].ay = pair_q.cb; axis[2].live = pair_q.hxb != '0;
    axis[3].ax = pair_q.cb;  axis[3].ay = pair_q.sb; axis[3].live = pair_q.hyb != '0;
  end

  for (genvar g = 0; g < 4; g++) begin : g_axis
    obot_axis u_axis (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .pair_i (pair_q),
      .axis_i (axis[g]),
      .sep_o  (sep[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      v1_q    <= s_axis_tvalid;
      v2_q    <= v1_q;
      v3_q    <= v2_q;
      v4_q    <= v3_q;
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      overlap_q <= !(|sep);
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{(obot_pkg::OutTdataW-1){1'b0}}, overlap_q};

  a_ready_follows_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("ready does not follow output stall");

  a_accept_reaches_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted beat lost at first stage");

  a_stage4_to_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v4_q && en) |=> m_axis_tvalid)
    else $error("pipeline beat did not reach output");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tdata[obot_pkg::OutTdataW-1:1] == '0)
    else $error("output padding not zero");

endmodule

@@ dv/obot_checker.sv @@
// ----------------------------------------------------------------------------
// obot_checker: overlap predictor and scoreboard for the box overlap core
// Watches both stream channels, computes the expected overlap flag of each
// accepted box pair and compares it with the returned beats in order.
// ----------------------------------------------------------------------------
module obot_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [obot_pkg::InTdataW-1:0]  s_axis_tdata,
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [obot_pkg::OutTdataW-1:0] m_axis_tdata,
  output int                             err_cnt_o,
  output int                             pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  bit overlap_q[$];

  // sine of 0..90 degrees, Q1.14, from a Q2.30 Taylor series
  function automatic longint quarter_wave(int deg);
    logic [63:0] x, x2, acc, term;
    x    = ((64'(deg) * 64'd13493037705) / 64'd180 + 64'd2) >> 2;
    x2   = (x * x) >> 30;
    acc  = x;
    term = x;
    for (int k = 1; k <= 7; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      acc  = (k % 2) ? acc - term : acc + term;
    end
    return longint'((acc + (64'd1 << (29 - obot_pkg::TrigFracBits)))
                    >> (30 - obot_pkg::TrigFracBits));
  endfunction

  function automatic longint sine_deg(int deg);
    deg = deg % obot_pkg::DegFullTurn;
    if (deg <= 90)  return quarter_wave(deg);
    if (deg <= 180) return quarter_wave(180 - deg);
    if (deg <= 270) return -quarter_wave(deg - 180);
    return -quarter_wave(360 - deg);
  endfunction

  function automatic bit predict_overlap(logic [obot_pkg::InTdataW-1:0] d);
    longint px[2][4], py[2][4], sn[2], cs[2], hx[2], hy[2];
    longint ax, ay, p, lo[2], hi[2], gap, cxx, cyy, tx, ty;
    int     ang, sx, sy, base;
    bit     sep;
    sep = 0;
    for (int b = 0; b < 2; b++) begin
      base  = b * 61;
      hx[b] = longint'(d[base +: 10]) >> 1;
      hy[b] = longint'(d[base + 10 +: 10]) >> 1;
      cxx   = longint'($signed(d[base + 20 +: 16])) <<< obot_pkg::TrigFracBits;
      cyy   = longint'($signed(d[base + 36 +: 16])) <<< obot_pkg::TrigFracBits;
      ang   = int'(d[base + 52 +: 9]);
      sn[b] = sine_deg(ang);
      cs[b] = sine_deg(ang + 90);
      for (int i = 0; i < 4; i++) begin
        sx = (i == 1 || i == 2) ? 1 : -1;
        sy = (i >= 2) ? 1 : -1;
        tx = hx[b] * 16 * sx;
        ty = hy[b] * 16 * sy;
        px[b][i] = cxx + tx * cs[b] - ty * sn[b];
        py[b][i] = cyy + tx * sn[b] + ty * cs[b];
      end
    end
    // top edge normal (-s, c) and side edge normal (c, s) of each box
    for (int k = 0; k < 4; k++) begin
      if (k % 2 == 0) begin
        if (hx[k / 2] == 0) continue;
        ax = -sn[k / 2];
        ay = cs[k / 2];
      end else begin
        if (hy[k / 2] == 0) continue;
        ax = cs[k / 2];
        ay = sn[k / 2];
      end
      for (int b = 0; b < 2; b++) begin
        lo[b] = ax * px[b][0] + ay * py[b][0];
        hi[b] = lo[b];
        for (int i = 1; i < 4; i++) begin
          p = ax * px[b][i] + ay * py[b][i];
          if (p < lo[b]) lo[b] = p;
          if (p > hi[b]) hi[b] = p;
        end
      end
      gap = (lo[0] < lo[1]) ? lo[1] - hi[0] : lo[0] - hi[1];
      if (gap > 0) sep = 1;
    end
    return !sep;
  endfunction

  assign pending_o = overlap_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    bit exp_ov;
    if (!rst_ni) begin
      err_cnt_o <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        overlap_q.push_back(predict_overlap(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (overlap_q.size() == 0) begin
          err_cnt_o <= err_cnt_o + 1;
          if (err_cnt_o < 10) $display("unexpected beat: overlap=%0b", m_axis_tdata[0]);
        end else begin
          exp_ov = overlap_q.pop_front();
          if (m_axis_tdata[0] !== exp_ov) begin
            err_cnt_o <= err_cnt_o + 1;
            if (err_cnt_o < 10)
              $display("overlap mismatch: expected %0b actual %0b", exp_ov, m_axis_tdata[0]);
          end
        end
      end
    end
  end

endmodule

@@ dv/tb_oriented_box_overlap_test_core.sv @@
// ----------------------------------------------------------------------------
// tb_oriented_box_overlap_test_core: stimulus and verdict for the overlap core
// Directed corner pairs, then random near and far box pairs with random
// stalls on both channels; the checker scores every returned beat.
// ----------------------------------------------------------------------------
module tb_oriented_box_overlap_test_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumRandom = 600;
  localparam int StallLimit = 5000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [obot_pkg::InTdataW-1:0]  s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [obot_pkg::OutTdataW-1:0] m_axis_tdata;
  int   err_cnt, pending, quiet_cycles;
  bit   steady;

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  oriented_box_overlap_test_core dut (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  obot_checker u_checker (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .err_cnt_o(err_cnt), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    if (rst_ni) m_axis_tready <= steady || ($urandom_range(99) >= 23);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // fields are taken modulo their width when packed
  task automatic send_pair(input int aw, ah, acx, acy, aang,
                           input int bw, bh, bcx, bcy, bang);
    bit taken;
    while (!steady && $urandom_range(99) < 23) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {6'b0, 9'(bang), 16'(bcy), 16'(bcx), 10'(bh), 10'(bw),
                      9'(aang), 16'(acy), 16'(acx), 10'(ah), 10'(aw)};
    taken = 0;
    while (!taken) begin
      @(negedge clk_i);
      taken = s_axis_tready;
      @(posedge clk_i);
    end
  endtask

  function automatic int rand_angle();
    return ($urandom_range(9) == 0) ? int'($urandom_range(511, 360))
                                    : int'($urandom_range(359));
  endfunction

  initial begin
    int aw, ah, bw, bh;
    int acx, acy, bcx, bcy;
    int span;
    steady = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: zero and full sizes, extreme centers, odd widths, wrapped angles
    send_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(1023, 1023, 32767, 32767, 0, 1023, 1023, -32768, -32768, 0);
    send_pair(1023, 1023, 0, 0, 45, 1023, 1023, 32767, 32767, 45);
    send_pair(20, 20, 0, 0, 0, 20, 20, 320, 0, 0);       // edges touch
    send_pair(20, 20, 0, 0, 0, 20, 20, 321, 0, 0);       // one LSB apart
    send_pair(21, 21, 0, 0, 0, 21, 21, 320, 0, 0);       // odd width truncates
    send_pair(0, 40, 0, 0, 90, 40, 0, 100, 100, 180);    // degenerate edges
    send_pair(1, 1, 0, 0, 270, 1, 1, 0, 0, 359);
    send_pair(100, 20, 0, 0, 360, 100, 20, 0, 400, 450);
    send_pair(100, 20, 0, 0, 511, 100, 20, 0, 400, 511);
    send_pair(200, 10, 0, 0, 45, 200, 10, -4096, -4096, 135);
    send_pair(200, 10, 0, 0, 30, 200, 10, 1600, 1600, 300);
    send_pair(50, 50, -32768, 32767, 90, 50, 50, -32768, 32767, 180);
    send_pair(512, 2, 100, 100, 1, 2, 512, 100, 100, 89);
    send_pair(1023, 1, 0, 0, 60, 1, 1023, 5000, 0, 120);
    send_pair(10, 10, 0, 0, 45, 10, 10, 226, 0, 45);

    for (int n = 0; n < NumRandom; n++) begin
      steady = (n >= 200 && n < 320);
      if ($urandom_range(9) == 0) begin
        aw = int'($urandom_range(1023)); ah = int'($urandom_range(1023));
        bw = int'($urandom_range(1023)); bh = int'($urandom_range(1023));
      end else begin
        aw = int'($urandom_range(120)); ah = int'($urandom_range(120));
        bw = int'($urandom_range(120)); bh = int'($urandom_range(120));
      end
      acx = int'($urandom_range(65535)); acy = int'($urandom_range(65535));
      if ($urandom_range(9) < 7) begin
        // near pair: offset comparable to the boxes, so both outcomes occur
        span = (aw + ah + bw + bh) * 8 + 16;
        bcx = acx + int'($urandom_range(2 * span)) - span;
        bcy = acy + int'($urandom_range(2 * span)) - span;
      end else begin
        bcx = int'($urandom_range(65535)); bcy = int'($urandom_range(65535));
      end
      send_pair(aw, ah, acx, acy, rand_angle(), bw, bh, bcx, bcy, rand_angle());
    end
    steady = 0;
    s_axis_tvalid <= 0;

    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/obot_pkg.sv
design/obot_trig.sv
design/obot_axis.sv
design/oriented_box_overlap_test_core.sv
dv/obot_checker.sv
dv/tb_oriented_box_overlap_test_core.sv
